// ===== hdl/asxu_pkg.sv =====
// Package: types, codes and sizes shared by the execute unit modules.
`default_nettype none
package asxu_pkg;
   localparam int NUM_REGS   = 12;
   localparam int MEM_WORDS  = 5;
   localparam int PROG_DEPTH = 256;
   localparam int REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MEM_IDX_W  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int JMP_W      = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
   localparam logic [31:0] ADDR_LO = 32'h0000_0100;
   localparam logic [31:0] ADDR_HI = 32'h0000_0110;
   localparam logic [31:0] SHIFT_MAX = 32'd31;

   typedef enum logic [3:0] {
      OP_MOV = 4'd0, OP_MVN = 4'd1, OP_CMP = 4'd2, OP_ADD = 4'd3,
      OP_SUB = 4'd4, OP_AND = 4'd5, OP_ORR = 4'd6, OP_EOR = 4'd7,
      OP_LSL = 4'd8, OP_LSR = 4'd9, OP_ASR = 4'd10, OP_ROR = 4'd11,
      OP_LDR = 4'd12, OP_STR = 4'd13, OP_B = 4'd14, OP_NOP = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      CC_AL = 3'd0, CC_EQ = 3'd1, CC_NE = 3'd2, CC_GT = 3'd3,
      CC_GE = 3'd4, CC_LT = 3'd5, CC_LE = 3'd6, CC_NV = 3'd7
   } cond_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SKIP  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_ADDR  = 2'd3;

   typedef struct packed {
      logic [3:0]  mode;
      logic [2:0]  cond;
      logic        set_flags;
      logic [3:0]  dest_reg;
      logic        first_is_reg;
      logic [3:0]  first_reg;
      logic [31:0] first_imm;
      logic        second_is_reg;
      logic [3:0]  second_reg;
      logic [31:0] second_imm;
      logic [7:0]  jump_target;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        reg_written;
      logic [3:0]  written_reg;
      logic [31:0] written_value;
      logic [3:0]  flags_nzcv;
      logic        jump_taken;
      logic [7:0]  jump_index;
   } rsp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      op_type      op;
      cond_type    cond;
      logic        set_flags;
      logic [3:0]  dest_reg;
      logic        first_is_reg;
      logic [3:0]  first_reg;
      logic [31:0] first_imm;
      logic        second_is_reg;
      logic [3:0]  second_reg;
      logic [31:0] second_imm;
      logic [7:0]  jump_index;
      logic        is_shift;
      logic        is_mem;
      logic        writes_reg;
   } uop_type;
endpackage
`default_nettype wire

// ===== hdl/arm_subset_execute_unit.sv =====
// Top level: front queue feeding the execute back end.
// One decoded instruction per item; a new item is taken every cycle while full is low. An
// item is held in the front queue (two entries) and executes combinationally
// in the back end, where register read, ALU or shifter and write back sit
// between the queue and the result register, which holds the result until it is
// popped; pop may overlap the next push.
`default_nettype none
module arm_subset_execute_unit import asxu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);
   logic    q_valid, q_take;
   uop_type q_data;

   asxu_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
   );

   asxu_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data),
      .q_take(q_take), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== hdl/asxu_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module asxu_front import asxu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         q_valid,
   output uop_type      q_data,
   input  wire logic    q_take
);
   localparam int DEPTH = 2;
   uop_type mem_ff [DEPTH];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   uop_type uop;
   logic do_push, do_pop;

   always_comb begin
      uop.op            = op_type'(req_data.mode);
      uop.cond          = cond_type'(req_data.cond);
      uop.set_flags     = req_data.set_flags;
      uop.dest_reg      = req_data.dest_reg;
      uop.first_is_reg  = req_data.first_is_reg;
      uop.first_reg     = req_data.first_reg;
      uop.first_imm     = req_data.first_imm;
      uop.second_is_reg = req_data.second_is_reg;
      uop.second_reg    = req_data.second_reg;
      uop.second_imm    = req_data.second_imm;
      uop.jump_index    = 8'(req_data.jump_target % PROG_DEPTH);
      uop.is_shift      = req_data.mode[3:2] == 2'b10;
      uop.is_mem        = req_data.mode == OP_LDR || req_data.mode == OP_STR;
      uop.writes_reg    = req_data.mode != OP_CMP && req_data.mode != OP_STR &&
                          req_data.mode != OP_B && req_data.mode != OP_NOP;
   end

   assign full    = cnt_ff == 2'(DEPTH);
   assign q_valid = cnt_ff != 2'd0;
   assign q_data  = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= uop;
   end
endmodule
`default_nettype wire

// ===== hdl/asxu_back.sv =====
// Back end: register file, data words, flags, ALU and result register.
`default_nettype none
module asxu_back import asxu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire uop_type q_data,
   output logic         q_take,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);
   logic [31:0] regs_ff [NUM_REGS];
   logic [31:0] words_ff [MEM_WORDS];
   logic [3:0]  flags_ff, flags_in;
   logic        full_ff, full_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] a, b, addr_reg, st_val, val, r, ld_val, sh_dist;
   logic        ok, n, z, v, wr, st, cs, ci, do_wr, bad;
   logic [31:0] word_off;
   logic [MEM_IDX_W-1:0] widx;
   logic [4:0]  sh;

   function automatic logic [31:0] rd(input logic [3:0] i, input logic [31:0] f [NUM_REGS]);
      logic [31:0] x;
      x = 32'd0;
      if (32'(i) < NUM_REGS) x = f[REG_IDX_W'(i)];
      return x;
   endfunction

   assign q_take = q_valid && (!full_ff || pop);
   assign empty = !full_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      n = flags_ff[3]; z = flags_ff[2]; v = flags_ff[0];
      case (q_data.cond)
         CC_AL:   ok = 1'b1;
         CC_EQ:   ok = z;
         CC_NE:   ok = !z;
         CC_GT:   ok = !z && (n == v);
         CC_GE:   ok = n == v;
         CC_LT:   ok = n != v;
         CC_LE:   ok = z || (n != v);
         default: ok = 1'b0;
      endcase
      a = q_data.first_is_reg ? rd(q_data.first_reg, regs_ff) : q_data.first_imm;
      b = q_data.second_is_reg ? rd(q_data.second_reg, regs_ff) : q_data.second_imm;
      addr_reg = rd(q_data.first_reg, regs_ff);
      st_val = rd(q_data.dest_reg, regs_ff);
      sh = b[4:0];
      sh_dist = 32'd32 - b;
      word_off = (addr_reg - ADDR_LO) >> 2;
      widx = MEM_IDX_W'(word_off);
      bad = addr_reg < ADDR_LO || addr_reg > ADDR_HI || addr_reg[1:0] != 2'b00 ||
            word_off >= 32'(MEM_WORDS);
      ld_val = bad ? 32'd0 : words_ff[widx];
      flags_in = flags_ff;
      val = 32'd0;
      st = 1'b0;
      rsp_in = '0;
      r = 32'd0;
      case (q_data.op)
         OP_MOV:  val = a;
         OP_MVN:  val = ~a;
         OP_CMP, OP_SUB: val = a - b;
         OP_ADD:  val = a + b;
         OP_AND:  val = a & b;
         OP_ORR:  val = a | b;
         OP_EOR:  val = a ^ b;
         OP_LSL:  val = a << sh;
         OP_LSR:  val = a >> sh;
         OP_ASR:  val = $unsigned($signed(a) >>> sh);
         OP_ROR:  val = (sh == 5'd0) ? a : ((a >> sh) | (a << sh_dist[5:0]));
         OP_LDR:  val = ld_val;
         default: val = 32'd0;
      endcase
      r = val;
      // Subtract carry is a >= b; the other ops that set C use the add-style rule.
      cs = a >= b;
      ci = r < a;
      if (!ok) begin
         rsp_in.status = ST_SKIP;
      end else if (q_data.is_shift && b > SHIFT_MAX) begin
         rsp_in.status = ST_SHIFT;
      end else if (q_data.is_mem && bad) begin
         rsp_in.status = ST_ADDR;
      end else begin
         rsp_in.status = ST_OK;
         st = q_data.op == OP_STR;
         case (q_data.op)
            OP_MVN: if (q_data.set_flags) flags_in = {r[31], r == 32'd0, flags_ff[1:0]};
            OP_CMP: flags_in = {r[31], r == 32'd0, cs, ((a ^ b) & (a ^ r)) >> 31 != 0};
            OP_SUB: if (q_data.set_flags)
               flags_in = {r[31], r == 32'd0, cs, ((a ^ b) & (a ^ r)) >> 31 != 0};
            OP_ADD, OP_AND, OP_ORR, OP_EOR: if (q_data.set_flags)
               flags_in = {r[31], r == 32'd0, ci, (~(a ^ b) & (a ^ r)) >> 31 != 0};
            OP_LSL, OP_LSR, OP_ASR, OP_ROR: if (q_data.set_flags)
               flags_in = {r[31], r == 32'd0, ci, (~a & (a ^ r)) >> 31 != 0};
            OP_B: begin
               rsp_in.jump_taken = 1'b1;
               rsp_in.jump_index = q_data.jump_index;
            end
            default: ;
         endcase
      end
      wr = rsp_in.status == ST_OK && q_data.writes_reg;
      do_wr = wr && 32'(q_data.dest_reg) < NUM_REGS;
      rsp_in.reg_written = do_wr;
      rsp_in.written_reg = do_wr ? q_data.dest_reg : 4'd0;
      rsp_in.written_value = do_wr ? r : 32'd0;
      rsp_in.flags_nzcv = flags_in;
      n = flags_in[3];
      full_in = q_take ? 1'b1 : (pop ? 1'b0 : full_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         flags_ff <= 4'd0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= 32'd0;
         for (int i = 0; i < MEM_WORDS; i++) words_ff[i] <= 32'd0;
      end else begin
         full_ff <= full_in;
         if (q_take) begin
            flags_ff <= flags_in;
            if (do_wr) regs_ff[REG_IDX_W'(q_data.dest_reg)] <= r;
            if (st) words_ff[widx] <= st_val;
         end
      end
      if (q_take) rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the execute unit: directed and random instructions checked against a model.
`timescale 1ns / 1ps
module testbench;
   import asxu_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full, empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   arm_subset_execute_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   // model state
   logic [31:0] regs_m [NUM_REGS];
   logic [31:0] mem_m [MEM_WORDS];
   logic [3:0]  nzcv_m;
   rsp_type     pending_rsp [$];

   int  errors = 0;
   int  cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_pop = 1'b0;
   int  hold_cycles = 0;
   localparam int CYCLE_LIMIT = 200000;

   initial forever #4 clock = ~clock;

   function automatic logic [31:0] read_reg(logic [3:0] i);
      return (i < NUM_REGS) ? regs_m[i] : 32'd0;
   endfunction

   function automatic bit cond_holds(logic [2:0] c);
      logic n, z, v;
      n = nzcv_m[3]; z = nzcv_m[2]; v = nzcv_m[0];
      case (cond_type'(c))
         CC_AL: return 1'b1;
         CC_EQ: return z;
         CC_NE: return !z;
         CC_GT: return !z && (n == v);
         CC_GE: return n == v;
         CC_LT: return n != v;
         CC_LE: return z || (n != v);
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [3:0] calc_flags(logic [31:0] r, logic [31:0] a, logic [31:0] b,
                                             bit sub);
      logic c, v;
      if (sub) begin
         c = a >= b;
         v = ((a ^ b) & (a ^ r)) >> 31 != 0;
      end else begin
         c = r < a;
         v = (~(a ^ b) & (a ^ r)) >> 31 != 0;
      end
      return {r[31], r == 32'd0, c, v};
   endfunction

   function automatic rsp_type execute_instr(req_type q);
      rsp_type     r;
      logic [31:0] a, b, val, addr;
      bit          wr;
      int          idx;
      r = '0; val = '0; wr = 1'b0;
      a = q.first_is_reg ? read_reg(q.first_reg) : q.first_imm;
      b = q.second_is_reg ? read_reg(q.second_reg) : q.second_imm;
      if (!cond_holds(q.cond)) begin
         r.status = ST_SKIP;
      end else begin
         case (op_type'(q.mode))
            OP_MOV: begin val = a; wr = 1'b1; end
            OP_MVN: begin
               val = ~a; wr = 1'b1;
               if (q.set_flags) nzcv_m = {val[31], val == 32'd0, nzcv_m[1:0]};
            end
            OP_CMP: nzcv_m = calc_flags(a - b, a, b, 1'b1);
            OP_ADD, OP_SUB, OP_AND, OP_ORR, OP_EOR: begin
               case (op_type'(q.mode))
                  OP_ADD: val = a + b;
                  OP_SUB: val = a - b;
                  OP_AND: val = a & b;
                  OP_ORR: val = a | b;
                  default: val = a ^ b;
               endcase
               wr = 1'b1;
               if (q.set_flags) nzcv_m = calc_flags(val, a, b, q.mode == OP_SUB);
            end
            OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
               if (b > SHIFT_MAX) begin
                  r.status = ST_SHIFT;
               end else begin
                  case (op_type'(q.mode))
                     OP_LSL: val = a << b[4:0];
                     OP_LSR: val = a >> b[4:0];
                     OP_ASR: val = $signed(a) >>> b[4:0];
                     default: val = (b == 0) ? a : ((a >> b[4:0]) | (a << (32 - b[4:0])));
                  endcase
                  wr = 1'b1;
                  if (q.set_flags) nzcv_m = calc_flags(val, a, 32'd0, 1'b0);
               end
            end
            OP_LDR, OP_STR: begin
               addr = read_reg(q.first_reg);
               idx = (addr - ADDR_LO) >> 2;
               if (addr < ADDR_LO || addr > ADDR_HI || addr[1:0] != 2'b00 || idx >= MEM_WORDS)
               begin
                  r.status = ST_ADDR;
               end else if (q.mode == OP_LDR) begin
                  val = mem_m[idx]; wr = 1'b1;
               end else begin
                  mem_m[idx] = read_reg(q.dest_reg);
               end
            end
            OP_B: begin
               r.jump_taken = 1'b1;
               r.jump_index = 8'(q.jump_target % PROG_DEPTH);
            end
            default: ;
         endcase
         if (wr && q.dest_reg < NUM_REGS) begin
            regs_m[q.dest_reg] = val;
            r.reg_written = 1'b1;
            r.written_reg = q.dest_reg;
            r.written_value = val;
         end
      end
      r.flags_nzcv = nzcv_m;
      return r;
   endfunction

   // send one item; waits for acceptance, leaves push high for the next item
   task automatic send_instr(req_type q);
      rsp_type exp_q;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (full) @(posedge clock);
      exp_q = execute_instr(q);
      pending_rsp.insert(pending_rsp.size(), exp_q);
   endtask

   // receiver: drive pop and check each accepted item
   always @(posedge clock) begin
      rsp_type exp_r;
      cycles <= cycles + 1;
      if (!reset && pop && !empty) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp_data.status !== exp_r.status || rsp_data.reg_written !== exp_r.reg_written
                || rsp_data.written_reg !== exp_r.written_reg
                || rsp_data.written_value !== exp_r.written_value
                || rsp_data.flags_nzcv !== exp_r.flags_nzcv
                || rsp_data.jump_taken !== exp_r.jump_taken
                || rsp_data.jump_index !== exp_r.jump_index) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_r, rsp_data);
               errors++;
            end
         end
      end
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      pop <= !reset && !(hold_pop || hold_cycles > 1)
             && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic wait_drain();
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type make_instr(op_type op, cond_type c, bit s, int rd);
      req_type q;
      q = '0;
      q.mode = op; q.cond = c; q.set_flags = s; q.dest_reg = 4'(rd);
      return q;
   endfunction

   // random instruction, biased to useful registers and shift amounts
   function automatic req_type rand_instr();
      req_type q;
      q = '0;
      q.mode = 4'($urandom_range(15));
      q.cond = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : CC_AL;
      q.set_flags = 1'($urandom_range(1));
      q.dest_reg = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
      q.first_is_reg = 1'($urandom_range(1));
      q.first_reg = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
      case ($urandom_range(3))
         0: q.first_imm = $urandom();
         1: q.first_imm = ADDR_LO + 4 * $urandom_range(5);
         2: q.first_imm = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'h8000_0000;
         default: q.first_imm = $urandom_range(300);
      endcase
      q.second_is_reg = 1'($urandom_range(1));
      q.second_reg = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(11));
      case ($urandom_range(3))
         0: q.second_imm = $urandom();
         1: q.second_imm = $urandom_range(33);
         default: q.second_imm = $urandom_range(8);
      endcase
      q.jump_target = 8'($urandom());
      // make memory ops usually hit the window
      if ((q.mode == OP_LDR || q.mode == OP_STR) && $urandom_range(3) != 0 && q.first_reg < 4)
         q.first_reg = 4'd0;
      return q;
   endfunction

   task automatic test_directed();
      req_type q;
      q = make_instr(OP_MOV, CC_AL, 1, 0); q.first_imm = ADDR_LO; send_instr(q);
      q = make_instr(OP_MOV, CC_AL, 0, 1); q.first_imm = 32'hFFFF_FFFF; send_instr(q);
      q = make_instr(OP_MVN, CC_AL, 1, 2); q.first_is_reg = 1; q.first_reg = 1; send_instr(q);
      q = make_instr(OP_CMP, CC_AL, 0, 0); q.first_imm = 5; q.second_imm = 5; send_instr(q);
      q = make_instr(OP_B, CC_EQ, 0, 0); q.jump_target = 8'hFF; send_instr(q);
      q = make_instr(OP_B, CC_NE, 0, 0); q.jump_target = 8'h12; send_instr(q);
      q = make_instr(OP_ADD, CC_AL, 1, 3); q.first_imm = 32'h7FFF_FFFF; q.second_imm = 1;
      send_instr(q);
      q = make_instr(OP_SUB, CC_GT, 1, 4); q.first_imm = 0; q.second_imm = 1; send_instr(q);
      q = make_instr(OP_AND, CC_LT, 1, 5); q.first_imm = 32'hF0F0; q.second_imm = 32'hFF;
      send_instr(q);
      q = make_instr(OP_ORR, CC_LE, 1, 6); q.first_imm = 0; q.second_imm = 0; send_instr(q);
      q = make_instr(OP_EOR, CC_GE, 1, 7); q.first_imm = 32'hAAAA_5555; q.second_imm = '1;
      send_instr(q);
      q = make_instr(OP_CMP, CC_NV, 0, 0); send_instr(q);
      q = make_instr(OP_LSL, CC_AL, 1, 8); q.first_imm = 32'h8000_0001; q.second_imm = 31;
      send_instr(q);
      q = make_instr(OP_LSR, CC_AL, 1, 8); q.first_imm = 32'h8000_0001; q.second_imm = 32;
      send_instr(q);
      q = make_instr(OP_ASR, CC_AL, 1, 9); q.first_imm = 32'h8000_0000; q.second_imm = 31;
      send_instr(q);
      q = make_instr(OP_ROR, CC_AL, 1, 10); q.first_imm = 32'h1234_5678; q.second_imm = 0;
      send_instr(q);
      q = make_instr(OP_ROR, CC_AL, 0, 10); q.first_imm = 32'h1234_5678; q.second_is_reg = 1;
      q.second_reg = 15; send_instr(q);
      q = make_instr(OP_STR, CC_AL, 0, 1); q.first_reg = 0; send_instr(q);
      q = make_instr(OP_LDR, CC_AL, 0, 11); q.first_reg = 0; send_instr(q);
      q = make_instr(OP_MOV, CC_AL, 0, 0); q.first_imm = ADDR_HI; send_instr(q);
      q = make_instr(OP_LDR, CC_AL, 0, 11); q.first_reg = 0; send_instr(q);
      q = make_instr(OP_STR, CC_AL, 0, 3); q.first_reg = 1; send_instr(q);
      q = make_instr(OP_MOV, CC_AL, 0, 15); q.first_imm = 7; send_instr(q);
      q = make_instr(OP_NOP, CC_AL, 1, 0); send_instr(q);
      wait_drain();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_instr(rand_instr());
      send_idle_pct = 0;
      wait_drain();
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_cycles = 60;
      repeat (20) send_instr(rand_instr());
      wait_drain();
      repeat (30) send_instr(rand_instr());
      // pause until all results are back, then continue
      wait_drain();
      repeat (30) send_instr(rand_instr());
      wait_drain();
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i++) regs_m[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) mem_m[i] = '0;
      nzcv_m = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 0, 0);
      test_random(130, 81, 0);
      test_random(130, 0, 81);
      test_random(120, 9, 9);
      test_backpressure();
      wait_drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
